// File: hdl/adrt_pkg.sv
// ----------------------------------------------------------------------------
// adrt_pkg
// Types and constants shared by the audio drift resample rate trim block.
// ----------------------------------------------------------------------------
package adrt_pkg;

    localparam int RATE_W   = 18;
    localparam int TOL_W    = 20;
    localparam int PREP_W   = 20;
    localparam int DUR_W    = 32;
    localparam int DRIFT_W  = 32;
    localparam int TOL3_W   = TOL_W + 2;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;

    localparam logic [RATE_W-1:0]  RATE_STEP     = RATE_W'(2);
    localparam logic [RATE_W-1:0]  RST_NOMINAL   = RATE_W'(48000);
    localparam logic [TOL_W-1:0]   RST_TOLERANCE = TOL_W'(40000);
    localparam logic [PREP_W-1:0]  RST_PREPARE   = PREP_W'(40000);

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_NOMINAL_RATE = 2'd0;
    localparam logic [1:0] REG_PTS_TOL      = 2'd1;
    localparam logic [1:0] REG_MIN_PREPARE  = 2'd2;
    localparam logic [1:0] REG_RESAMPLER    = 2'd3;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef struct packed {
        logic [RATE_W-1:0] nominal_rate;
        logic [TOL_W-1:0]  pts_tolerance;
        logic [PREP_W-1:0] min_prepare;
        logic              resampler_present;
    } cfg_t;

    typedef struct packed {
        dir_t                       direction;
        logic [RATE_W-1:0]          current_rate;
        logic signed [DRIFT_W-1:0]  start_drift;
    } trim_state_t;

    typedef struct packed {
        logic action;
        logic clear_queue;
        logic break_continuity;
    } flags_t;

endpackage

// File: hdl/adrt_decide.sv
// ----------------------------------------------------------------------------
// adrt_decide
// Combinational decision for one audio buffer: queue checks, retiming and
// the next resampler trim state.
// ----------------------------------------------------------------------------
module adrt_decide #(
    parameter int TIME_BITS = 48
) (
    input  adrt_pkg::cfg_t              cfg,
    input  adrt_pkg::trim_state_t       st,
    input  logic [TIME_BITS-1:0]        now_time,
    input  logic [TIME_BITS-1:0]        buffer_start,
    input  logic [adrt_pkg::DUR_W-1:0]  buffer_duration,
    input  logic [TIME_BITS-1:0]        expected_start,
    output adrt_pkg::trim_state_t       st_next,
    output adrt_pkg::flags_t            flags,
    output logic [TIME_BITS-1:0]        push_start,
    output logic [TIME_BITS-1:0]        push_end
);

    localparam int TW = TIME_BITS;
    localparam int SW = TIME_BITS + 1;

    logic [adrt_pkg::TOL3_W-1:0]       tol3;
    logic [TW-1:0]                     expv;
    logic [SW-1:0]                     now_prep;
    logic [TW-1:0]                     now_prep_sat;
    logic [TW-1:0]                     bsv;
    logic [TW-1:0]                     sd;
    logic [TW-1:0]                     cur_mag;
    logic [SW-1:0]                     exp_tol3;
    logic [SW-1:0]                     bs_tol3;
    logic [SW-1:0]                     sd_tol;
    logic [SW-1:0]                     bs_tol;
    logic [SW-1:0]                     end_sum;
    logic [adrt_pkg::DRIFT_W-1:0]      st_mag;
    logic [adrt_pkg::DRIFT_W-1:0]      half_mag;
    logic [adrt_pkg::DRIFT_W+1:0]      st_mag3;
    logic [adrt_pkg::DRIFT_W:0]        wide_thr;
    adrt_pkg::dir_t                    dir;
    logic [adrt_pkg::RATE_W-1:0]       rate;
    logic signed [adrt_pkg::DRIFT_W-1:0] drift;
    logic                              drp;
    logic                              clr;
    logic                              brk;

    // Three tolerances, as a shift and add.
    assign tol3 = (adrt_pkg::TOL3_W'(cfg.pts_tolerance) << 1)
                + adrt_pkg::TOL3_W'(cfg.pts_tolerance);

    always_comb
    begin
        dir      = st.direction;
        rate     = st.current_rate;
        drift    = st.start_drift;
        drp      = 1'b0;
        clr      = 1'b0;
        brk      = 1'b0;
        expv     = expected_start;
        sd       = '0;
        cur_mag  = '0;
        sd_tol   = '0;
        bs_tol   = '0;
        st_mag   = '0;
        half_mag = '0;
        st_mag3  = '0;
        wide_thr = '0;
        end_sum  = '0;
        push_start = '0;
        push_end   = '0;

        // A queue start that already lies in the past is stale.
        if (expv != '0 && expv < now_time)
        begin
            clr = 1'b1;
            dir = adrt_pkg::DIR_NONE;
            if (cfg.resampler_present)
            begin
                rate = cfg.nominal_rate;
                brk  = 1'b1;
            end
            expv = '0;
        end

        now_prep     = {1'b0, now_time} + SW'(cfg.min_prepare);
        now_prep_sat = now_prep[TW] ? '1 : now_prep[TW-1:0];
        bsv          = (buffer_start < now_time) ? now_prep_sat : buffer_start;
        exp_tol3     = {1'b0, expv} + SW'(tol3);
        bs_tol3      = {1'b0, bsv} + SW'(tol3);

        if ({1'b0, bsv} < now_prep)
        begin
            drp = 1'b1;
            dir = adrt_pkg::DIR_NONE;
            if (cfg.resampler_present)
            begin
                rate = cfg.nominal_rate;
                brk  = 1'b1;
            end
        end
        else if (expv != '0 && exp_tol3 < {1'b0, bsv})
        begin
            clr = 1'b1;
            dir = adrt_pkg::DIR_NONE;
            if (cfg.resampler_present)
            begin
                rate = cfg.nominal_rate;
                brk  = 1'b1;
            end
            expv = '0;
        end
        else if (expv != '0 && bs_tol3 < {1'b0, expv})
        begin
            drp = 1'b1;
        end

        if (!drp)
        begin
            sd      = (expv == '0) ? bsv : expv;
            cur_mag = (bsv > sd) ? bsv - sd : sd - bsv;
            sd_tol  = {1'b0, sd} + SW'(cfg.pts_tolerance);
            bs_tol  = {1'b0, bsv} + SW'(cfg.pts_tolerance);

            if (dir == adrt_pkg::DIR_NONE && cfg.resampler_present &&
                (sd_tol < {1'b0, bsv} || bs_tol < {1'b0, sd}))
            begin
                if (bsv > sd)
                begin
                    drift = (cur_mag > TW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                          : signed'(cur_mag[31:0]);
                    dir   = adrt_pkg::DIR_DOWN;
                end
                else
                begin
                    drift = (cur_mag >= TW'(64'h8000_0000)) ? 32'sh8000_0000
                                                           : -signed'(cur_mag[31:0]);
                    dir   = adrt_pkg::DIR_UP;
                end
            end

            if (dir != adrt_pkg::DIR_NONE)
            begin
                case (dir)
                    adrt_pkg::DIR_UP: rate = rate + adrt_pkg::RATE_STEP;
                    default:          rate = rate - adrt_pkg::RATE_STEP;
                endcase

                st_mag   = drift[adrt_pkg::DRIFT_W-1] ? unsigned'(-drift)
                                                      : unsigned'(drift);
                half_mag = {1'b0, st_mag[adrt_pkg::DRIFT_W-1:1]};
                st_mag3  = {2'b00, st_mag} + {1'b0, st_mag, 1'b0};
                wide_thr = st_mag3[adrt_pkg::DRIFT_W+1:1];

                if (rate == cfg.nominal_rate)
                begin
                    dir = adrt_pkg::DIR_NONE;
                end
                else if ({1'b0, cur_mag} < SW'(half_mag))
                begin
                    case (dir)
                        adrt_pkg::DIR_UP: dir = adrt_pkg::DIR_DOWN;
                        default:          dir = adrt_pkg::DIR_UP;
                    endcase
                    drift = '0;
                end
                else if (drift != '0 && {1'b0, cur_mag} > SW'(wide_thr))
                begin
                    dir  = adrt_pkg::DIR_NONE;
                    rate = cfg.nominal_rate;
                end
            end

            end_sum    = {1'b0, sd} + SW'(buffer_duration);
            push_start = sd;
            push_end   = end_sum[TW] ? '1 : end_sum[TW-1:0];
        end
    end

    assign st_next.direction     = dir;
    assign st_next.current_rate  = rate;
    assign st_next.start_drift   = drift;
    assign flags.action           = drp;
    assign flags.clear_queue      = clr;
    assign flags.break_continuity = brk;

endmodule

// File: hdl/audio_drift_resample_rate_trim_top.sv
// ----------------------------------------------------------------------------
// audio_drift_resample_rate_trim_top
// Per-buffer drift control: retimes audio buffers against the output queue
// and trims the resampler rate in 2 Hz steps toward the timestamp target.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Word
//  in        in_valid / in_stall  now_time, buffer_start, buffer_duration,
//                                 expected_start
//  out       out_valid/ out_stall action, clear_queue, break_continuity,
//                                 push_start, push_end, resample_rate,
//                                 trim_direction
//  config    APB write/read       nominal_rate, pts_tolerance, min_prepare,
//                                 resampler_present
//
//  One word is taken every cycle while in_stall is low; its result is
//  offered from the result register, which follows the input register.
//  The trim state is updated in the single cycle in which a word moves from
//  the input register to the result register, so consecutive words see it.
//  A stalled output holds the result register; in_stall rises only when
//  the output is stalled and both the input and result registers are full.
//  Reset loads the register defaults and clears the trim state.
// ----------------------------------------------------------------------------
module audio_drift_resample_rate_trim_top #(
    parameter int TIME_BITS = 48
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [adrt_pkg::ADDR_W-1:0]    paddr,
    input  logic [adrt_pkg::DATA_W-1:0]    pwdata,
    output logic [adrt_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [TIME_BITS-1:0]           now_time,
    input  logic [TIME_BITS-1:0]           buffer_start,
    input  logic [adrt_pkg::DUR_W-1:0]     buffer_duration,
    input  logic [TIME_BITS-1:0]           expected_start,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           action,
    output logic                           clear_queue,
    output logic                           break_continuity,
    output logic [TIME_BITS-1:0]           push_start,
    output logic [TIME_BITS-1:0]           push_end,
    output logic [adrt_pkg::RATE_W-1:0]    resample_rate,
    output logic [1:0]                     trim_direction
);

    adrt_pkg::cfg_t                cfg_reg;
    adrt_pkg::trim_state_t         st_reg;
    adrt_pkg::trim_state_t         st_next;
    adrt_pkg::flags_t              flags_next;
    adrt_pkg::flags_t              flags_reg;

    logic                          in_vld_reg;
    logic [TIME_BITS-1:0]          now_reg;
    logic [TIME_BITS-1:0]          bs_reg;
    logic [adrt_pkg::DUR_W-1:0]    dur_reg;
    logic [TIME_BITS-1:0]          exp_reg;

    logic                          out_vld_reg;
    logic [TIME_BITS-1:0]          ps_reg;
    logic [TIME_BITS-1:0]          pe_reg;
    logic [TIME_BITS-1:0]          ps_next;
    logic [TIME_BITS-1:0]          pe_next;
    logic [adrt_pkg::RATE_W-1:0]   rate_reg;
    adrt_pkg::dir_t                dir_reg;

    logic                          cfg_wr;
    logic                          in_take;
    logic                          advance;
    logic                          out_take;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign out_take = out_vld_reg & ~out_stall;
    assign advance  = in_vld_reg & (~out_vld_reg | ~out_stall);
    assign in_stall = in_vld_reg & ~advance;
    assign in_take  = in_valid & ~in_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.nominal_rate      <= adrt_pkg::RST_NOMINAL;
            cfg_reg.pts_tolerance     <= adrt_pkg::RST_TOLERANCE;
            cfg_reg.min_prepare       <= adrt_pkg::RST_PREPARE;
            cfg_reg.resampler_present <= 1'b1;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                adrt_pkg::REG_NOMINAL_RATE:
                    cfg_reg.nominal_rate <= pwdata[adrt_pkg::RATE_W-1:0];
                adrt_pkg::REG_PTS_TOL:
                    cfg_reg.pts_tolerance <= pwdata[adrt_pkg::TOL_W-1:0];
                adrt_pkg::REG_MIN_PREPARE:
                    cfg_reg.min_prepare <= pwdata[adrt_pkg::PREP_W-1:0];
                adrt_pkg::REG_RESAMPLER:
                    cfg_reg.resampler_present <= pwdata[0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            adrt_pkg::REG_NOMINAL_RATE:
                prdata = adrt_pkg::DATA_W'(cfg_reg.nominal_rate);
            adrt_pkg::REG_PTS_TOL:
                prdata = adrt_pkg::DATA_W'(cfg_reg.pts_tolerance);
            adrt_pkg::REG_MIN_PREPARE:
                prdata = adrt_pkg::DATA_W'(cfg_reg.min_prepare);
            adrt_pkg::REG_RESAMPLER:
                prdata = adrt_pkg::DATA_W'(cfg_reg.resampler_present);
            default:
                prdata = '0;
        endcase
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_reg <= now_time;
            bs_reg  <= buffer_start;
            dur_reg <= buffer_duration;
            exp_reg <= expected_start;
        end
    end

    adrt_decide #(
        .TIME_BITS (TIME_BITS)
    ) u_decide (
        .cfg             (cfg_reg),
        .st              (st_reg),
        .now_time        (now_reg),
        .buffer_start    (bs_reg),
        .buffer_duration (dur_reg),
        .expected_start  (exp_reg),
        .st_next         (st_next),
        .flags           (flags_next),
        .push_start      (ps_next),
        .push_end        (pe_next)
    );

    // Trim state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.direction    <= adrt_pkg::DIR_NONE;
            st_reg.current_rate <= adrt_pkg::RST_NOMINAL;
            st_reg.start_drift  <= '0;
            out_vld_reg         <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                st_reg      <= st_next;
                out_vld_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            flags_reg <= flags_next;
            ps_reg    <= ps_next;
            pe_reg    <= pe_next;
            rate_reg  <= st_next.current_rate;
            dir_reg   <= st_next.direction;
        end
    end

    assign out_valid        = out_vld_reg;
    assign action           = flags_reg.action;
    assign clear_queue      = flags_reg.clear_queue;
    assign break_continuity = flags_reg.break_continuity;
    assign push_start       = ps_reg;
    assign push_end         = pe_reg;
    assign resample_rate    = rate_reg;
    assign trim_direction   = dir_reg;

endmodule

// File: hdl/adrt_checker.sv
// ----------------------------------------------------------------------------
// adrt_checker
// Port-level checks for the audio drift resample rate trim block.
// ----------------------------------------------------------------------------
module adrt_checker #(
    parameter int TIME_BITS = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 action,
    input  logic                 clear_queue,
    input  logic                 break_continuity,
    input  logic [TIME_BITS-1:0] push_start,
    input  logic [TIME_BITS-1:0] push_end
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word withdrawn while stalled");

    // A dropped buffer carries no dates.
    a_drop_dates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action |-> push_start == '0 && push_end == '0)
        else $error("dropped buffer carries dates");

    // The retimed end never lies before the retimed start.
    a_end_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !action |-> push_end >= push_start)
        else $error("push_end before push_start");

    // Continuity only breaks together with a queue clear or a drop.
    a_break_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && break_continuity |-> clear_queue || action)
        else $error("continuity break without clear or drop");

endmodule

bind audio_drift_resample_rate_trim_top adrt_checker #(
    .TIME_BITS (TIME_BITS)
) u_adrt_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .action           (action),
    .clear_queue      (clear_queue),
    .break_continuity (break_continuity),
    .push_start       (push_start),
    .push_end         (push_end)
);

// File: tb/tb_audio_drift_resample_rate_trim_top.sv
// ----------------------------------------------------------------------------
// tb_audio_drift_resample_rate_trim_top
// Self-checking bench for the audio drift resample rate trim block. Buffer
// words are sent with random gaps and results are taken under random stalls.
// A local model of the drift decision and rate trim predicts every result.
// Directed words cover each decision path, then well-formed trim runs and
// random noise run under a sweep of register settings, extremes included.
// ----------------------------------------------------------------------------
module tb_audio_drift_resample_rate_trim_top;

    localparam int TIME_W = 48;
    localparam longint unsigned TIME_MAX = (64'd1 << TIME_W) - 1;

    typedef struct packed {
        logic [TIME_W-1:0]          now_time;
        logic [TIME_W-1:0]          buffer_start;
        logic [adrt_pkg::DUR_W-1:0] buffer_duration;
        logic [TIME_W-1:0]          expected_start;
    } buffer_word_t;

    typedef struct packed {
        adrt_pkg::flags_t            flags;
        logic [TIME_W-1:0]           push_start;
        logic [TIME_W-1:0]           push_end;
        logic [adrt_pkg::RATE_W-1:0] rate;
        logic [1:0]                  direction;
    } decision_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [adrt_pkg::ADDR_W-1:0]   paddr;
    logic [adrt_pkg::DATA_W-1:0]   pwdata;
    logic [adrt_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_stall;
    logic [TIME_W-1:0]             now_time;
    logic [TIME_W-1:0]             buffer_start;
    logic [adrt_pkg::DUR_W-1:0]    buffer_duration;
    logic [TIME_W-1:0]             expected_start;
    logic                          out_valid;
    logic                          out_stall;
    logic                          action;
    logic                          clear_queue;
    logic                          break_continuity;
    logic [TIME_W-1:0]             push_start;
    logic [TIME_W-1:0]             push_end;
    logic [adrt_pkg::RATE_W-1:0]   resample_rate;
    logic [1:0]                    trim_direction;

    adrt_pkg::cfg_t                cfg_shadow;
    adrt_pkg::trim_state_t         trim;
    decision_t                     pending_decisions[$];
    int                            error_count = 0;
    int                            words_sent = 0;
    int                            in_gap_max = 5;
    int                            out_gap_max = 5;

    audio_drift_resample_rate_trim_top #(
        .TIME_BITS(TIME_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .now_time(now_time),
        .buffer_start(buffer_start),
        .buffer_duration(buffer_duration),
        .expected_start(expected_start),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .action(action),
        .clear_queue(clear_queue),
        .break_continuity(break_continuity),
        .push_start(push_start),
        .push_end(push_end),
        .resample_rate(resample_rate),
        .trim_direction(trim_direction)
    );

    always #1 clk = ~clk;

    function automatic void report_failure(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic string format_decision(input decision_t d);
        return $sformatf("act %b clr %b brk %b start %h end %h rate %0d dir %0d",
            d.flags.action, d.flags.clear_queue, d.flags.break_continuity,
            d.push_start, d.push_end, d.rate, d.direction);
    endfunction

    function automatic longint unsigned sat_time(input longint unsigned t);
        return (t > TIME_MAX) ? TIME_MAX : t;
    endfunction

    // Stops any trim in progress; continuity breaks only when a resampler exists.
    function automatic logic abandon_trim();
        trim.direction = adrt_pkg::DIR_NONE;
        if (cfg_shadow.resampler_present)
        begin
            trim.current_rate = cfg_shadow.nominal_rate;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic decision_t predict_decision(input buffer_word_t w);
        longint unsigned now, bs, dur, queued, tol, tol3, prep, sd, mag, st_mag;
        longint          sl;
        int              sdr;
        decision_t       d;
        now    = w.now_time;
        bs     = w.buffer_start;
        dur    = w.buffer_duration;
        queued = w.expected_start;
        tol    = cfg_shadow.pts_tolerance;
        tol3   = tol * 3;
        prep   = cfg_shadow.min_prepare;
        d      = '0;

        if (queued != 0 && queued < now)
        begin
            d.flags.clear_queue = 1'b1;
            if (abandon_trim())
                d.flags.break_continuity = 1'b1;
            queued = 0;
        end

        if (bs < now)
            bs = sat_time(now + prep);

        if (bs < now + prep)
        begin
            d.flags.action = 1'b1;
            if (abandon_trim())
                d.flags.break_continuity = 1'b1;
        end
        else if (queued != 0 && queued + tol3 < bs)
        begin
            d.flags.clear_queue = 1'b1;
            if (abandon_trim())
                d.flags.break_continuity = 1'b1;
            queued = 0;
        end
        else if (queued != 0 && bs + tol3 < queued)
        begin
            d.flags.action = 1'b1;
        end

        if (!d.flags.action)
        begin
            sd  = (queued == 0) ? bs : queued;
            mag = (bs > sd) ? bs - sd : sd - bs;

            if (trim.direction == adrt_pkg::DIR_NONE && cfg_shadow.resampler_present &&
                (sd + tol < bs || bs + tol < sd))
            begin
                if (bs > sd)
                begin
                    trim.start_drift = (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                            : adrt_pkg::DRIFT_W'(mag);
                    trim.direction   = adrt_pkg::DIR_DOWN;
                end
                else
                begin
                    trim.start_drift = (mag >= 64'h8000_0000) ? 32'sh8000_0000
                                                             : adrt_pkg::DRIFT_W'(-mag);
                    trim.direction   = adrt_pkg::DIR_UP;
                end
            end

            if (trim.direction != adrt_pkg::DIR_NONE)
            begin
                if (trim.direction == adrt_pkg::DIR_UP)
                    trim.current_rate = trim.current_rate + adrt_pkg::RATE_STEP;
                else
                    trim.current_rate = trim.current_rate - adrt_pkg::RATE_STEP;
                sdr    = trim.start_drift;
                sl     = sdr;
                st_mag = (sl < 0) ? -sl : sl;
                if (trim.current_rate == cfg_shadow.nominal_rate)
                begin
                    trim.direction = adrt_pkg::DIR_NONE;
                end
                else if (mag < st_mag / 2)
                begin
                    trim.direction   = (trim.direction == adrt_pkg::DIR_UP)
                                       ? adrt_pkg::DIR_DOWN : adrt_pkg::DIR_UP;
                    trim.start_drift = '0;
                end
                else if (sdr != 0 && mag > (st_mag * 3) / 2)
                begin
                    trim.direction    = adrt_pkg::DIR_NONE;
                    trim.current_rate = cfg_shadow.nominal_rate;
                end
            end

            d.push_start = TIME_W'(sd);
            d.push_end   = TIME_W'(sat_time(sd + dur));
        end

        d.rate      = trim.current_rate;
        d.direction = trim.direction;
        return d;
    endfunction

    function automatic logic [TIME_W-1:0] random_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    function automatic buffer_word_t buffer_word(input longint unsigned now,
                                                 input longint unsigned bs,
                                                 input longint unsigned dur,
                                                 input longint unsigned queued);
        buffer_word_t w;
        w.now_time        = TIME_W'(now);
        w.buffer_start    = TIME_W'(bs);
        w.buffer_duration = adrt_pkg::DUR_W'(dur);
        w.expected_start  = TIME_W'(queued);
        return w;
    endfunction

    function automatic buffer_word_t noise_word();
        buffer_word_t    w;
        longint unsigned prep;
        prep              = cfg_shadow.min_prepare;
        w.now_time        = random_time();
        w.buffer_start    = random_time();
        w.buffer_duration = $urandom;
        w.expected_start  = random_time();
        case ($urandom_range(0, 3))
            0: ;
            1:
            begin
                w.buffer_start   = w.now_time + TIME_W'($urandom_range(0, 32'(2 * prep + 2)));
                w.expected_start = '0;
            end
            2: w.expected_start = w.now_time - TIME_W'($urandom_range(1, 1000));
            default: w.buffer_start = w.now_time - TIME_W'($urandom_range(1, 100000));
        endcase
        return w;
    endfunction

    task automatic apb_transfer(input logic [1:0] idx, input logic is_write,
                                input logic [adrt_pkg::DATA_W-1:0] wdata,
                                output logic [adrt_pkg::DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(input logic [1:0] idx);
        logic [adrt_pkg::DATA_W-1:0] rdata;
        logic [adrt_pkg::DATA_W-1:0] want;
        case (idx)
            adrt_pkg::REG_NOMINAL_RATE:
                want = adrt_pkg::DATA_W'(cfg_shadow.nominal_rate);
            adrt_pkg::REG_PTS_TOL:
                want = adrt_pkg::DATA_W'(cfg_shadow.pts_tolerance);
            adrt_pkg::REG_MIN_PREPARE:
                want = adrt_pkg::DATA_W'(cfg_shadow.min_prepare);
            default:
                want = adrt_pkg::DATA_W'(cfg_shadow.resampler_present);
        endcase
        apb_transfer(idx, 1'b0, '0, rdata);
        if (rdata !== want)
            report_failure($sformatf("register %0d read %h, expected %h", idx, rdata, want));
    endtask

    task automatic write_register(input logic [1:0] idx,
                                  input logic [adrt_pkg::DATA_W-1:0] value);
        logic [adrt_pkg::DATA_W-1:0] unused;
        apb_transfer(idx, 1'b1, value, unused);
        case (idx)
            adrt_pkg::REG_NOMINAL_RATE:
                cfg_shadow.nominal_rate = value[adrt_pkg::RATE_W-1:0];
            adrt_pkg::REG_PTS_TOL:
                cfg_shadow.pts_tolerance = value[adrt_pkg::TOL_W-1:0];
            adrt_pkg::REG_MIN_PREPARE:
                cfg_shadow.min_prepare = value[adrt_pkg::PREP_W-1:0];
            default:
                cfg_shadow.resampler_present = value[0];
        endcase
        check_register(idx);
    endtask

    // Returns at the edge that takes the word, with valid still high, so a
    // following word with no gap keeps valid up without a glitch.
    task automatic send_buffer_word(input buffer_word_t w);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        now_time        <= w.now_time;
        buffer_start    <= w.buffer_start;
        buffer_duration <= w.buffer_duration;
        expected_start  <= w.expected_start;
        in_valid        <= 1'b1;
        do @(posedge clk); while (in_stall);
        pending_decisions.push_back(predict_decision(w));
        words_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic pick_idle_profile();
        in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 5;
        out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
    endtask

    // A queue that runs steadily off its timestamps: the drift starts beyond
    // the tolerance and then shrinks, grows, holds or wanders.
    task automatic run_trim_sequence(input int steps);
        longint unsigned tol, prep, base, anchor, d0, drift, reach;
        logic            below;
        int              mode;
        buffer_word_t    w;
        tol   = cfg_shadow.pts_tolerance;
        prep  = cfg_shadow.min_prepare;
        reach = 4 * tol + 16;
        d0    = (tol == 0) ? $urandom_range(1, 8) : tol + 1 + $urandom_range(0, 32'(2 * tol - 1));
        drift = d0;
        below = $urandom_range(0, 1);
        mode  = $urandom_range(0, 3);
        base  = random_time() >> 2;
        repeat (steps)
        begin
            base   += $urandom_range(100, 60000);
            anchor  = base + prep + reach + $urandom_range(0, 1000);
            if (drift > reach)
                drift = reach;
            w.now_time        = TIME_W'(base);
            w.buffer_start    = TIME_W'(below ? anchor - drift : anchor + drift);
            w.buffer_duration = ($urandom_range(0, 7) == 0) ? $urandom
                                                            : $urandom_range(0, 200000);
            case ($urandom_range(0, 15))
                0:       w.expected_start = '0;
                1:       w.expected_start = TIME_W'(base - 1);
                default: w.expected_start = TIME_W'(anchor);
            endcase
            send_buffer_word(w);
            case (mode)
                0:       drift = drift * 3 / 4;
                1:       drift = drift + drift / 8 + 1;
                2:       drift = d0 + $urandom_range(0, 16);
                default: drift = $urandom_range(0, 32'(reach));
            endcase
        end
    endtask

    task automatic run_random_traffic();
        pick_idle_profile();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) send_buffer_word(noise_word());
        else
            run_trim_sequence($urandom_range(4, 30));
    endtask

    task automatic test_register_defaults();
        check_register(adrt_pkg::REG_NOMINAL_RATE);
        check_register(adrt_pkg::REG_PTS_TOL);
        check_register(adrt_pkg::REG_MIN_PREPARE);
        check_register(adrt_pkg::REG_RESAMPLER);
    endtask

    task automatic test_directed_buffers();
        longint unsigned n, q, tol, prep;
        n    = 1000000;
        q    = n + 200000;
        tol  = adrt_pkg::RST_TOLERANCE;
        prep = adrt_pkg::RST_PREPARE;
        send_buffer_word(buffer_word(n, n + prep + 10, 0, 0));
        send_buffer_word(buffer_word(n, n - 5, 1000, 0));
        send_buffer_word(buffer_word(n, n + prep - 1, 1000, 0));
        send_buffer_word(buffer_word(n, n, 1000, 0));
        send_buffer_word(buffer_word(n, n + prep + 500, 1000, n - 1));
        send_buffer_word(buffer_word(n, q + 3 * tol + 1, 1000, q));
        send_buffer_word(buffer_word(n, q - 3 * tol - 1, 1000, q));
        // Trim down, fall below half the start drift, then step back to nominal.
        send_buffer_word(buffer_word(n, q + 50000, 1000, q));
        send_buffer_word(buffer_word(n, q + 10000, 1000, q));
        send_buffer_word(buffer_word(n, q + 10000, 1000, q));
        send_buffer_word(buffer_word(n, q + 10000, 1000, q));
        // Trim up, then a drift past one and a half times the start aborts it.
        send_buffer_word(buffer_word(n, q - 50000, 1000, q));
        send_buffer_word(buffer_word(n, q - 80000, 1000, q));
        send_buffer_word(buffer_word(n, q + 3 * tol, 1000, q));
        send_buffer_word(buffer_word(n, q, 1000, n - 1));
        send_buffer_word(buffer_word(TIME_MAX, 0, 0, 0));
        send_buffer_word(buffer_word(0, TIME_MAX, 32'hFFFF_FFFF, 0));
        send_buffer_word(buffer_word(0, TIME_MAX - 10, 32'hFFFF_FFFF, TIME_MAX));
        send_buffer_word(buffer_word(0, 0, 0, 0));
        send_buffer_word(buffer_word(TIME_MAX, TIME_MAX, 32'hFFFF_FFFF, TIME_MAX));
        send_buffer_word(buffer_word(n, q + tol, 1000, q));
        send_buffer_word(buffer_word(n, q + tol + 1, 1000, q));
        wait_idle();
    endtask

    task automatic test_trim_sequences();
        while (words_sent < 200)
            run_random_traffic();
        wait_idle();
    endtask

    task automatic test_register_sweep();
        int phase;
        int target;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:
                begin
                    write_register(adrt_pkg::REG_NOMINAL_RATE, 0);
                    write_register(adrt_pkg::REG_MIN_PREPARE, 0);
                end
                1:
                begin
                    write_register(adrt_pkg::REG_NOMINAL_RATE, 32'h3FFFF);
                    write_register(adrt_pkg::REG_PTS_TOL, 32'hFFFFF);
                    write_register(adrt_pkg::REG_MIN_PREPARE, 32'hFFFFF);
                end
                2:
                begin
                    write_register(adrt_pkg::REG_PTS_TOL, 0);
                    write_register(adrt_pkg::REG_NOMINAL_RATE, $urandom_range(0, 262143));
                    write_register(adrt_pkg::REG_MIN_PREPARE, $urandom_range(0, 100000));
                end
                3: write_register(adrt_pkg::REG_PTS_TOL, $urandom_range(1, 100000));
                4:
                begin
                    // The resampler goes away while a trim is running.
                    run_trim_sequence(3);
                    wait_idle();
                    write_register(adrt_pkg::REG_RESAMPLER, 0);
                end
                5:
                begin
                    write_register(adrt_pkg::REG_RESAMPLER, 1);
                    run_trim_sequence(3);
                    wait_idle();
                    write_register(adrt_pkg::REG_NOMINAL_RATE, $urandom_range(47000, 49000));
                end
                6:
                begin
                    write_register(adrt_pkg::REG_PTS_TOL, 1);
                    write_register(adrt_pkg::REG_MIN_PREPARE, 1);
                end
                default:
                begin
                    write_register(adrt_pkg::REG_NOMINAL_RATE, $urandom_range(0, 262143));
                    write_register(adrt_pkg::REG_PTS_TOL, $urandom_range(1, 1048575));
                    write_register(adrt_pkg::REG_MIN_PREPARE, $urandom_range(0, 1048575));
                end
            endcase
            target = words_sent + 25;
            while (words_sent < target)
                run_random_traffic();
            wait_idle();
        end
    endtask

    always @(posedge clk)
    begin : result_checker
        decision_t got;
        decision_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.flags.action           = action;
            got.flags.clear_queue      = clear_queue;
            got.flags.break_continuity = break_continuity;
            got.push_start             = push_start;
            got.push_end               = push_end;
            got.rate                   = resample_rate;
            got.direction              = trim_direction;
            if (pending_decisions.size() == 0)
            begin
                report_failure({"unexpected result word: ", format_decision(got)});
            end
            else
            begin
                want = pending_decisions.pop_front();
                if (got !== want)
                    report_failure({"result mismatch: got ", format_decision(got),
                                    " expected ", format_decision(want)});
            end
        end
    end

    // Receiver: holds off for a random number of cycles, then takes one word.
    initial
    begin : result_stall_driver
        int n;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            n = $urandom_range(0, out_gap_max);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_valid        = 1'b0;
        now_time        = '0;
        buffer_start    = '0;
        buffer_duration = '0;
        expected_start  = '0;
        cfg_shadow      = '{adrt_pkg::RST_NOMINAL, adrt_pkg::RST_TOLERANCE,
                            adrt_pkg::RST_PREPARE, 1'b1};
        trim            = '{adrt_pkg::DIR_NONE, adrt_pkg::RST_NOMINAL, '0};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_defaults();
        test_directed_buffers();
        test_trim_sequences();
        test_register_sweep();

        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hdl/adrt_pkg.sv
hdl/adrt_decide.sv
hdl/audio_drift_resample_rate_trim_top.sv
hdl/adrt_checker.sv
tb/tb_audio_drift_resample_rate_trim_top.sv
